/* rtl/lrukv_pkg.sv */
// Shared constants and types for the LRU key-value cache.
// Self-contained; used by lru_key_value_cache.
`default_nettype none
package lrukv_pkg;

  localparam int KEY_W = 16;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int DEFAULT_MAX_ENTRIES = 16;

  // Configuration port: one 32-bit register at byte address 0.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lrukv_pkg for widths, codes and the entry record type.
`default_nettype none
// Each word is a get or a put on a 16-bit key. The block takes one word at a time:
// it scans all MAX_ENTRIES slots through a single read port of the key/value and
// age memories, one slot per cycle, then decides, then (except for a get miss)
// makes a second pass over the slots to update ages and write the entry. A new
// word may be accepted while the previous result still waits in the output
// register; the finish step of that word then waits until the previous result
// is taken. Valid bits are cleared at reset, so no clearing pass is needed.
// The capacity register (byte address 0, reset 16) limits how many entries are
// held before a put of a new key evicts the least recent one; 0 acts as 1 and
// values above MAX_ENTRIES act as MAX_ENTRIES.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lrukv_pkg::DEFAULT_MAX_ENTRIES
) (
  input  wire                               clk,
  input  wire                               rst,
  // Configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [lrukv_pkg::ADDR_W-1:0]       paddr,
  input  wire [lrukv_pkg::DATA_W-1:0]       pwdata,
  output logic [lrukv_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  // Request channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               op,
  input  wire [lrukv_pkg::KEY_W-1:0]        lookup_key,
  input  wire signed [lrukv_pkg::VAL_W-1:0] write_value,
  // Response channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              hit,
  output logic signed [lrukv_pkg::VAL_W-1:0] read_value,
  output logic                              evicted
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AGE_W = IDX_W;
  localparam int CMP_W = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration register
  logic [lrukv_pkg::CAP_W-1:0] capacity;

  assign pready = 1'b1;
  assign prdata = (paddr[lrukv_pkg::ADDR_W-1] == lrukv_pkg::REG_CAPACITY) ?
                  lrukv_pkg::DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrukv_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[lrukv_pkg::ADDR_W-1] == lrukv_pkg::REG_CAPACITY) begin
      capacity <= pwdata[lrukv_pkg::CAP_W-1:0];
    end
  end

  // Entry storage
  lrukv_pkg::entry_t kv_mem [MAX_ENTRIES];
  logic [AGE_W-1:0]  age_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;

  lrukv_pkg::entry_t kv_rd;
  logic [AGE_W-1:0]  age_rd;
  logic [IDX_W-1:0]  rd_addr;
  logic              kv_we;
  logic              age_we;
  lrukv_pkg::entry_t kv_wdata;
  logic [AGE_W-1:0]  age_wdata;

  // Pass control
  logic [CNT_W-1:0] cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;

  // Latched request
  logic                               op_q;
  logic [lrukv_pkg::KEY_W-1:0]        key_q;
  logic signed [lrukv_pkg::VAL_W-1:0] val_q;

  // Scan results
  logic [CNT_W-1:0]                   count;
  logic                               found_ok;
  logic [IDX_W-1:0]                   found_idx;
  logic [AGE_W-1:0]                   found_age;
  logic signed [lrukv_pkg::VAL_W-1:0] found_value;
  logic                               victim_ok;
  logic [IDX_W-1:0]                   victim_idx;
  logic [AGE_W-1:0]                   victim_age;
  logic                               free_ok;
  logic [IDX_W-1:0]                   free_idx;

  // Update plan and pending result
  logic [IDX_W-1:0]                   target;
  logic [AGE_W-1:0]                   thresh;
  logic                               mode_all;
  logic                               res_hit;
  logic signed [lrukv_pkg::VAL_W-1:0] res_val;
  logic                               res_ev;

  logic [CMP_W-1:0] cap_eff;
  logic             full;
  logic             scanning;
  logic             is_target;
  logic             upd_slot;
  logic             pass_done;

  assign in_ready = (state == ST_IDLE);
  assign rd_addr  = cnt[IDX_W-1:0];
  assign scanning = (state == ST_SCAN) || (state == ST_UPDATE);
  assign pass_done = rd_pend && (rd_idx == LAST_IDX);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
    full = CMP_W'(count) >= cap_eff;
  end

  // Second pass: the target slot gets the new record with age zero; other valid
  // slots age by one when they were younger than the target, or always on insert.
  always_comb begin
    is_target      = (rd_idx == target);
    upd_slot       = (state == ST_UPDATE) && rd_pend;
    kv_we          = upd_slot && is_target;
    age_we         = upd_slot && (is_target ||
                     (valid[rd_idx] && (mode_all || age_rd < thresh)));
    kv_wdata.key   = key_q;
    kv_wdata.value = (op_q == lrukv_pkg::OP_PUT) ? val_q : kv_rd.value;
    age_wdata      = is_target ? '0 : age_rd + AGE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      kv_mem[rd_idx] <= kv_wdata;
    end
    if (age_we) begin
      age_mem[rd_idx] <= age_wdata;
    end
    kv_rd  <= kv_mem[rd_addr];
    age_rd <= age_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      rd_pend <= scanning && (cnt != CNT_END);
      rd_idx  <= rd_addr;
      if (scanning && cnt != CNT_END) begin
        cnt <= cnt + CNT_W'(1);
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q      <= op;
            key_q     <= lookup_key;
            val_q     <= write_value;
            count     <= '0;
            found_ok  <= 1'b0;
            victim_ok <= 1'b0;
            free_ok   <= 1'b0;
            cnt       <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_pend) begin
            if (valid[rd_idx]) begin
              count <= count + CNT_W'(1);
              if (kv_rd.key == key_q) begin
                found_ok    <= 1'b1;
                found_idx   <= rd_idx;
                found_age   <= age_rd;
                found_value <= kv_rd.value;
              end
              if (!victim_ok || age_rd > victim_age) begin
                victim_ok  <= 1'b1;
                victim_idx <= rd_idx;
                victim_age <= age_rd;
              end
            end else if (!free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          if (pass_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt <= '0;
          if (found_ok) begin
            res_hit  <= 1'b1;
            res_val  <= (op_q == lrukv_pkg::OP_PUT) ? '0 : found_value;
            res_ev   <= 1'b0;
            target   <= found_idx;
            thresh   <= found_age;
            mode_all <= 1'b0;
            state    <= ST_UPDATE;
          end else if (op_q == lrukv_pkg::OP_GET) begin
            res_hit <= 1'b0;
            res_val <= lrukv_pkg::MISS_VALUE;
            res_ev  <= 1'b0;
            state   <= ST_FINISH;
          end else begin
            res_hit  <= 1'b0;
            res_val  <= '0;
            mode_all <= 1'b1;
            state    <= ST_UPDATE;
            if (full && victim_ok) begin
              // The freed victim slot competes with the first empty slot.
              res_ev <= 1'b1;
              if (free_ok && free_idx < victim_idx) begin
                target <= free_idx;
                valid  <= (valid & ~(MAX_ENTRIES'(1) << victim_idx)) |
                          (MAX_ENTRIES'(1) << free_idx);
              end else begin
                target <= victim_idx;
              end
            end else begin
              res_ev          <= 1'b0;
              target          <= free_idx;
              valid[free_idx] <= 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          if (pass_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            hit        <= res_hit;
            read_value <= res_val;
            evicted    <= res_ev;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared outside the finish step");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCAN && cnt == '0))
    else $error("accepted word did not start a scan from slot zero");

  a_target_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && rd_pend && rd_idx == target) |-> valid[target])
    else $error("update pass writes a slot that is not valid");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> !hit)
    else $error("eviction reported together with a hit");
`endif

endmodule
`default_nettype wire
